[hdl/bqd_pkg.sv]
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared widths, constants and pipeline control types for the block-scaled
// int8 dot product.
// ----------------------------------------------------------------------------
package bqd_pkg;

  localparam int unsigned Lanes     = 16;
  localparam int unsigned HalfLanes = Lanes / 2;
  localparam int unsigned ElemW     = 8;
  localparam int unsigned ProdW     = 2 * ElemW;
  localparam int unsigned DotW      = 20;
  localparam int unsigned ScaleW    = 16;
  localparam int unsigned TermW     = 36;
  localparam int unsigned AccW      = 56;
  localparam int unsigned OutW      = 48;
  localparam int unsigned FracBits  = 12;

  typedef logic signed [ProdW-1:0] prod_t;

  // control carried alongside the lane data
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ScaleW-1:0] block_scale;
    logic [ScaleW-1:0] row_scale;
  } ctl_t;

  // finished row handed to the output scaler
  typedef struct packed {
    logic              valid;
    logic [ScaleW-1:0] row_scale;
  } row_req_t;

endpackage

[hdl/block_quantized_int8_dot.sv]
// ----------------------------------------------------------------------------
// block_quantized_int8_dot
// Block-scaled int8 dot product with row accumulation and Q4.12 scaling.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel (in_valid_i / in_ready_o) carries
// one 16-element block of int8 activations and weights with its Q4.12 block
// scale. Blocks of one output row are sent in order; the block with
// last_block_i set also carries the row scale and closes the row.
// Only a closing block produces a response on the output channel
// (out_valid_o / out_ready_i): the Q.12 row result, saturated to 48 bits,
// with saturated_o marking a clip.
// Throughput is one block per cycle while the output is not stalled. From
// the accepting edge of a closing block to out_valid_o there are six register
// stages, the first loaded at the accepting edge: lane multiply, adder tree,
// block scale multiply, accumulator, row scale multiply, round and saturate.
// The accumulator add, fed back from its own register, sets that rate.
// When the receiver stalls with a response pending, the whole pipeline holds
// and in_ready_o drops; it rises again the cycle the response is taken.
// Reset clears the accumulator and all pipeline valid bits.
// ----------------------------------------------------------------------------
module block_quantized_int8_dot (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [63:0]          act_lanes_low_i,
  input  logic [63:0]          act_lanes_high_i,
  input  logic [63:0]          wgt_lanes_low_i,
  input  logic [63:0]          wgt_lanes_high_i,
  input  logic [15:0]          block_scale_i,
  input  logic [15:0]          row_scale_i,
  input  logic                 last_block_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [47:0]   dot_result_o,
  output logic                 saturated_o
);

  localparam int unsigned ElemW = bqd_pkg::ElemW;

  logic                     en;
  bqd_pkg::prod_t           prod [bqd_pkg::Lanes];
  bqd_pkg::ctl_t            ctl_d, ctl1_q;
  bqd_pkg::row_req_t        row_req;
  logic signed [bqd_pkg::AccW-1:0] row_acc;

  // pipeline advances unless a response sits unread
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  for (genvar g = 0; g < bqd_pkg::Lanes; g++) begin : g_lane
    logic signed [ElemW-1:0] act, wgt;
    if (g < bqd_pkg::HalfLanes) begin : g_low
      assign act = act_lanes_low_i[ElemW*g +: ElemW];
      assign wgt = wgt_lanes_low_i[ElemW*g +: ElemW];
    end else begin : g_high
      assign act = act_lanes_high_i[ElemW*(g-bqd_pkg::HalfLanes) +: ElemW];
      assign wgt = wgt_lanes_high_i[ElemW*(g-bqd_pkg::HalfLanes) +: ElemW];
    end
    bqd_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .act_i  (act),
      .wgt_i  (wgt),
      .prod_o (prod[g])
    );
  end

  always_comb begin
    ctl_d.valid       = in_valid_i;
    ctl_d.last        = last_block_i;
    ctl_d.block_scale = block_scale_i;
    ctl_d.row_scale   = row_scale_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (en) begin
      ctl1_q <= ctl_d;
    end
  end

  bqd_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .prod_i (prod),
    .ctl_i  (ctl1_q),
    .row_o  (row_req),
    .acc_o  (row_acc)
  );

  bqd_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .row_i        (row_req),
    .acc_i        (row_acc),
    .out_valid_o  (out_valid_o),
    .dot_result_o (dot_result_o),
    .saturated_o  (saturated_o)
  );

endmodule

[hdl/bqd_lane.sv]
// ----------------------------------------------------------------------------
// bqd_lane
// One lane: signed int8 by int8 multiply with a registered product.
// ----------------------------------------------------------------------------
module bqd_lane (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [bqd_pkg::ElemW-1:0]  act_i,
  input  logic signed [bqd_pkg::ElemW-1:0]  wgt_i,
  output bqd_pkg::prod_t                    prod_o
);

  localparam int unsigned ProdW = bqd_pkg::ProdW;

  bqd_pkg::prod_t prod_d, prod_q;

  assign prod_d = ProdW'(act_i) * ProdW'(wgt_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[hdl/bqd_merge.sv]
// ----------------------------------------------------------------------------
// bqd_merge
// Merges the lane products: adder tree, block scale multiply and the row
// accumulator with 56-bit saturation.
// ----------------------------------------------------------------------------
module bqd_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  bqd_pkg::prod_t                      prod_i [bqd_pkg::Lanes],
  input  bqd_pkg::ctl_t                       ctl_i,
  output bqd_pkg::row_req_t                   row_o,
  output logic signed [bqd_pkg::AccW-1:0]     acc_o
);

  localparam int unsigned AccW  = bqd_pkg::AccW;
  localparam int unsigned DotW  = bqd_pkg::DotW;
  localparam int unsigned TermW = bqd_pkg::TermW;

  logic signed [DotW-1:0]  sum2 [bqd_pkg::HalfLanes];
  logic signed [DotW-1:0]  sum4 [bqd_pkg::HalfLanes/2];
  logic signed [DotW-1:0]  sum8 [bqd_pkg::HalfLanes/4];
  logic signed [DotW-1:0]  dot_d, dot_q;
  logic signed [TermW:0]   term_full;
  logic signed [TermW-1:0] term_q;
  logic signed [AccW:0]    acc_sum;
  logic signed [AccW-1:0]  acc_sat, acc_d, acc_q, fin_acc_q;
  bqd_pkg::ctl_t           ctl2_q, ctl3_q;
  bqd_pkg::row_req_t       row_d, row_q;

  // balanced adder tree over the lanes
  always_comb begin
    for (int i = 0; i < bqd_pkg::HalfLanes; i++) begin
      sum2[i] = DotW'(prod_i[2*i]) + DotW'(prod_i[2*i+1]);
    end
    for (int i = 0; i < bqd_pkg::HalfLanes / 2; i++) begin
      sum4[i] = sum2[2*i] + sum2[2*i+1];
    end
    for (int i = 0; i < bqd_pkg::HalfLanes / 4; i++) begin
      sum8[i] = sum4[2*i] + sum4[2*i+1];
    end
    dot_d = sum8[0] + sum8[1];
  end

  assign term_full = (TermW+1)'(dot_q) * (TermW+1)'($signed({1'b0, ctl2_q.block_scale}));

  // accumulate and clip at the signed 56-bit limits
  always_comb begin
    acc_sum = {acc_q[AccW-1], acc_q} + (AccW+1)'(term_q);
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_sat = acc_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[AccW-1:0];
    end
    acc_d = acc_q;
    if (ctl3_q.valid) begin
      acc_d = ctl3_q.last ? '0 : acc_sat;
    end
    row_d.valid     = ctl3_q.valid && ctl3_q.last;
    row_d.row_scale = ctl3_q.row_scale;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
      row_q  <= '0;
      acc_q  <= '0;
    end else if (en_i) begin
      ctl2_q <= ctl_i;
      ctl3_q <= ctl2_q;
      row_q  <= row_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q     <= dot_d;
      term_q    <= term_full[TermW-1:0];
      fin_acc_q <= acc_sat;
    end
  end

  assign row_o = row_q;
  assign acc_o = fin_acc_q;

endmodule

[hdl/bqd_scale.sv]
// ----------------------------------------------------------------------------
// bqd_scale
// Row scale: magnitude times Q4.12 scale, round half away from zero,
// saturate to 48 bits, and hold the result in the output register.
// ----------------------------------------------------------------------------
module bqd_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  bqd_pkg::row_req_t                  row_i,
  input  logic signed [bqd_pkg::AccW-1:0]    acc_i,
  output logic                               out_valid_o,
  output logic signed [bqd_pkg::OutW-1:0]    dot_result_o,
  output logic                               saturated_o
);

  localparam int unsigned AccW   = bqd_pkg::AccW;
  localparam int unsigned OutW   = bqd_pkg::OutW;
  localparam int unsigned Frac   = bqd_pkg::FracBits;
  localparam int unsigned ScaleW = bqd_pkg::ScaleW;
  localparam int unsigned HiW    = AccW - Frac;
  localparam int unsigned HiPW   = HiW + ScaleW;
  localparam int unsigned LoPW   = Frac + ScaleW;
  localparam int unsigned ResW   = HiPW + 1;

  logic [AccW-1:0]  mag;
  logic [HiPW-1:0]  hi_prod_q;
  logic [LoPW-1:0]  lo_prod_q;
  logic             neg_q, valid5_q;
  logic [LoPW:0]    lo_round;
  logic [ResW-1:0]  res;
  logic [OutW-1:0]  lim, res_clip;
  logic             sat_d;
  logic             out_valid_q;
  logic signed [OutW-1:0] dot_q;
  logic             sat_q;

  assign mag = acc_i[AccW-1] ? AccW'(-acc_i) : AccW'(acc_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid5_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      valid5_q    <= row_i.valid;
      out_valid_q <= valid5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_prod_q <= HiPW'(mag[AccW-1:Frac]) * HiPW'(row_i.row_scale);
      lo_prod_q <= LoPW'(mag[Frac-1:0]) * LoPW'(row_i.row_scale);
      neg_q     <= acc_i[AccW-1];
    end
  end

  // ties go away from zero since rounding is done on the magnitude
  always_comb begin
    lo_round = (LoPW+1)'(lo_prod_q) + (LoPW+1)'(1 << (Frac - 1));
    res      = ResW'(hi_prod_q) + ResW'(lo_round >> Frac);
    lim      = neg_q ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
    sat_d    = res > ResW'(lim);
    res_clip = sat_d ? lim : res[OutW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid5_q) begin
      dot_q <= neg_q ? $signed(-res_clip) : $signed(res_clip);
      sat_q <= sat_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dot_result_o = dot_q;
  assign saturated_o  = sat_q;

endmodule
